### rtl/sgai_pkg.sv
package sgai_pkg;

   // result status codes
   localparam logic [1:0] STAT_FILL  = 2'd0;
   localparam logic [1:0] STAT_MOVE  = 2'd1;
   localparam logic [1:0] STAT_VALID = 2'd2;

   localparam int FRAC_W = 14;
   localparam int QUO_W  = 16;
   localparam int XR_W   = 30;

   localparam logic signed [15:0]     ONE_Q14 = 16'sd16384;
   localparam logic signed [XR_W-1:0] ONE_Q28 = 30'sd268435456;

   typedef logic signed [15:0] q14_type;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_SQ_NEW = 16'h0002,
      ST_SQ_OLD = 16'h0004,
      ST_ACCUM  = 16'h0008,
      ST_VAR_SS = 16'h0010,
      ST_VAR_NQ = 16'h0020,
      ST_LIM0   = 16'h0040,
      ST_LIM1   = 16'h0080,
      ST_LIM2   = 16'h0100,
      ST_TEST   = 16'h0200,
      ST_SQRT   = 16'h0400,
      ST_NDIV   = 16'h0800,
      ST_XR     = 16'h1000,
      ST_XSQ    = 16'h2000,
      ST_CROSS  = 16'h4000,
      ST_OUT    = 16'h8000
   } state_type;

endpackage

### rtl/sgai_mul.sv
// Shift-add multiplier, one bit of b per cycle; stops once b runs out of ones.
module sgai_mul #(
   parameter int A_W = 40,
   parameter int B_W = 29
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] prod
);

   logic               run_ff;
   logic               done_ff;
   logic [A_W+B_W-1:0] acc_ff;
   logic [A_W+B_W-1:0] a_ff;
   logic [B_W-1:0]     b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (b_ff == '0)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= (A_W+B_W)'(a);
         b_ff   <= b;
      end else if (run_ff && (b_ff != '0)) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### rtl/sgai_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees num < den * 2^16.
module sgai_div #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 29
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   output logic                         done,
   output logic [sgai_pkg::QUO_W-1:0]   quo
);

   localparam int QW  = sgai_pkg::QUO_W;
   localparam int CW  = $clog2(QW + 1);

   logic              run_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QW-1:0]     num_ff;
   logic [QW-1:0]     quo_ff;
   logic [DEN_W:0]    rem_sh;
   logic [DEN_W:0]    rem_sub;
   logic              fits;

   assign rem_sh  = {rem_ff, num_ff[QW-1]};
   assign rem_sub = rem_sh - {1'b0, den};
   assign fits    = rem_sh >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == '0)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(num[NUM_W-1:QW]);
         num_ff <= num[QW-1:0];
         cnt_ff <= CW'(QW);
         quo_ff <= '0;
      end else if (run_ff && (cnt_ff != '0)) begin
         rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_ff <= {quo_ff[QW-2:0], fits};
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### rtl/static_gravity_attitude_init_core.sv
// Static gravity-alignment attitude initializer.
// req_ channel: one accelerometer beat (accel_x/y/z, signed counts) per item.
// rsp_ channel: one result beat per item: status plus a 3x3 rotation in Q1.14
//   (row 0 x axis, row 1 y axis, row 2 gravity axis). Rotation is zero unless
//   status is attitude valid.
// csr_ channel: writes max_std (valid/ready, ready while the core is idle).
// The first WINDOW beats after reset only fill the window and give status
// filling. From then on each beat slides the window and gives motion or a
// valid attitude.
// Almost all of an item's work is done in the shared shift-add multiplier,
// which retires one bit of its shorter operand per cycle; the root takes
// one result bit a cycle.
// One item is in work at a time; req_stall is high from accept until the
// result is parked in the output register, which lets the next beat in
// while the last result still waits. A stalled rsp_ holds the core in its
// final step. Reset (synchronous) empties the window, clears the sums and
// sets max_std to 256.
module static_gravity_attitude_init_core #(
   parameter int WINDOW = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_rot_r0c0,
   output logic signed [15:0] rsp_rot_r0c1,
   output logic signed [15:0] rsp_rot_r0c2,
   output logic signed [15:0] rsp_rot_r1c0,
   output logic signed [15:0] rsp_rot_r1c1,
   output logic signed [15:0] rsp_rot_r1c2,
   output logic signed [15:0] rsp_rot_r2c0,
   output logic signed [15:0] rsp_rot_r2c1,
   output logic signed [15:0] rsp_rot_r2c2,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_max_std
);

   localparam int LOG_W = $clog2(WINDOW);
   localparam int SUM_W = 16 + LOG_W;          // signed axis sum
   localparam int SQS_W = 31 + LOG_W;          // axis sum of squares
   localparam int SPR_W = 34 + 2 * LOG_W;      // spread and limit
   localparam int BW    = (16 + LOG_W > 29) ? 16 + LOG_W : 29;  // serial operand
   localparam int AW    = 33 + LOG_W;          // parallel operand
   localparam int PW    = AW + BW;
   localparam int RT_W  = BW;                  // root width
   localparam int SQV_W = 2 * RT_W;            // squared norm width
   localparam int NUM_W = BW + 15;
   localparam int RC_W  = $clog2(RT_W + 1);
   localparam int XR_W  = sgai_pkg::XR_W;
   localparam int FW    = sgai_pkg::FRAC_W;

   sgai_pkg::state_type state_ff, state_in;

   logic                    busy_ff;
   logic [1:0]              ax_ff;
   logic                    sub_ff;
   logic                    phase_ff;
   logic [LOG_W-1:0]        wp_ff;
   logic [LOG_W:0]          fill_ff;
   logic [15:0]             max_std_ff;
   logic                    rsp_valid_ff;

   logic signed [15:0]      smp_ff [3];
   logic [47:0]             ring [WINDOW];
   logic [47:0]             ring_rd_ff;
   logic signed [SUM_W-1:0] sum_ff [3];
   logic [SQS_W-1:0]        sqs_ff [3];
   logic [30:0]             sq_new_ff [3];
   logic [30:0]             sq_old_ff [3];
   logic [SPR_W-1:0]        spread_ff;
   logic [SPR_W-1:0]        lim_ff;
   logic [SQV_W-1:0]        msq_ff;
   logic [SQV_W-1:0]        sq_val_ff;
   logic [RT_W+1:0]         sq_rem_ff;
   logic [RT_W-1:0]         sq_root_ff;
   logic [RC_W-1:0]         sq_cnt_ff;
   logic [RT_W-1:0]         root_ff;
   sgai_pkg::q14_type       z_ff [3];
   sgai_pkg::q14_type       x_ff [3];
   sgai_pkg::q14_type       y_ff [3];
   logic signed [XR_W-1:0]  xr_ff [3];
   logic signed [30:0]      cross_ff;
   logic [1:0]              stat_ff;

   logic [1:0]              rsp_status_ff;
   sgai_pkg::q14_type       rsp_rot_ff [9];

   // combinational helpers
   logic                    acc_go;
   logic                    full;
   logic                    last_ax;
   logic                    mul_state;
   logic                    loop_state;
   logic                    op_done;
   logic                    last_step;
   logic [1:0]              pi, qi;
   logic signed [15:0]      old_s [3];
   logic [15:0]             smp_mag [3];
   logic [15:0]             old_mag [3];
   logic [SUM_W-1:0]        sum_mag [3];
   logic [15:0]             z_mag [3];
   logic [15:0]             x_mag [3];
   logic [XR_W-1:0]         xr_mag [3];
   logic                    mul_start;
   logic [AW-1:0]           mul_a;
   logic [BW-1:0]           mul_b;
   logic                    mul_neg;
   logic                    mul_done;
   logic [PW-1:0]           mul_prod;
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic                    div_neg;
   logic                    div_done;
   logic [sgai_pkg::QUO_W-1:0] div_quo;
   logic [BW-1:0]           nrm_mag;
   logic [XR_W-1:0]         xr_prod;
   logic signed [30:0]      prod_s;
   logic signed [30:0]      cross_diff;
   logic [30:0]             diff_mag;
   logic [16:0]             round_mag;
   logic [15:0]             sat_mag;
   logic [RT_W+3:0]         rt_sh;
   logic [RT_W+3:0]         rt_trial;
   logic [RT_W+3:0]         rt_sub;
   logic                    rt_fits;

   assign acc_go    = req_valid && !req_stall;
   assign full      = (fill_ff == (LOG_W+1)'(WINDOW));
   assign last_ax   = (ax_ff == 2'd2);
   assign req_stall = (state_ff != sgai_pkg::ST_IDLE);
   assign csr_ready = (state_ff == sgai_pkg::ST_IDLE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         old_s[i]   = ring_rd_ff[16*i +: 16];
         smp_mag[i] = smp_ff[i][15] ? 16'(-smp_ff[i]) : 16'(smp_ff[i]);
         old_mag[i] = old_s[i][15] ? 16'(-old_s[i]) : 16'(old_s[i]);
         sum_mag[i] = sum_ff[i][SUM_W-1] ? SUM_W'(-sum_ff[i]) : SUM_W'(sum_ff[i]);
         z_mag[i]   = z_ff[i][15] ? 16'(-z_ff[i]) : 16'(z_ff[i]);
         x_mag[i]   = x_ff[i][15] ? 16'(-x_ff[i]) : 16'(x_ff[i]);
         xr_mag[i]  = xr_ff[i][XR_W-1] ? XR_W'(-xr_ff[i]) : XR_W'(xr_ff[i]);
      end
   end

   // cross product pairing: y[ax] = z[p]*x[q] - z[q]*x[p]
   always_comb begin
      case (ax_ff)
         2'd0:    begin pi = 2'd1; qi = 2'd2; end
         2'd1:    begin pi = 2'd2; qi = 2'd0; end
         default: begin pi = 2'd0; qi = 2'd1; end
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_state = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      mul_neg   = 1'b0;
      case (state_ff)
         sgai_pkg::ST_SQ_NEW: begin
            mul_a = AW'(smp_mag[ax_ff]);
            mul_b = BW'(smp_mag[ax_ff]);
         end
         sgai_pkg::ST_SQ_OLD: begin
            mul_a = AW'(old_mag[ax_ff]);
            mul_b = BW'(old_mag[ax_ff]);
         end
         sgai_pkg::ST_VAR_SS: begin
            mul_a = AW'(sum_mag[ax_ff]);
            mul_b = BW'(sum_mag[ax_ff]);
         end
         sgai_pkg::ST_VAR_NQ: begin
            mul_a = AW'(sqs_ff[ax_ff]);
            mul_b = BW'(WINDOW);
         end
         sgai_pkg::ST_LIM0: begin
            mul_a = AW'(max_std_ff);
            mul_b = BW'(max_std_ff);
         end
         sgai_pkg::ST_LIM1, sgai_pkg::ST_LIM2: begin
            mul_a = lim_ff[AW-1:0];
            mul_b = BW'(WINDOW);
         end
         sgai_pkg::ST_XR: begin
            mul_a   = AW'(z_mag[0]);
            mul_b   = BW'(z_mag[ax_ff]);
            mul_neg = z_ff[0][15] ^ z_ff[ax_ff][15];
         end
         sgai_pkg::ST_XSQ: begin
            mul_a = AW'(xr_mag[ax_ff]);
            mul_b = BW'(xr_mag[ax_ff]);
         end
         sgai_pkg::ST_CROSS: begin
            if (!sub_ff) begin
               mul_a   = AW'(z_mag[pi]);
               mul_b   = BW'(x_mag[qi]);
               mul_neg = z_ff[pi][15] ^ x_ff[qi][15];
            end else begin
               mul_a   = AW'(z_mag[qi]);
               mul_b   = BW'(x_mag[pi]);
               mul_neg = z_ff[qi][15] ^ x_ff[pi][15];
            end
         end
         default: mul_state = 1'b0;
      endcase
   end

   assign mul_start = mul_state && !busy_ff;

   sgai_mul #(.A_W(AW), .B_W(BW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // normalize: num = |v| * 2^14 + floor(r / 2), den = r
   assign nrm_mag = phase_ff ? BW'(xr_mag[ax_ff]) : BW'(sum_mag[ax_ff]);
   assign div_neg = phase_ff ? xr_ff[ax_ff][XR_W-1] : sum_ff[ax_ff][SUM_W-1];
   assign div_num = {1'b0, nrm_mag, FW'(0)} + NUM_W'(root_ff >> 1);
   assign div_start = (state_ff == sgai_pkg::ST_NDIV) && !busy_ff && (root_ff != '0);

   sgai_div #(.NUM_W(NUM_W), .DEN_W(RT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (root_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // product as signed, cross difference, round half away and saturate
   assign xr_prod    = mul_prod[XR_W-1:0];
   assign prod_s     = mul_neg ? -31'(signed'({1'b0, xr_prod})) : 31'(signed'({1'b0, xr_prod}));
   assign cross_diff = cross_ff - prod_s;
   assign diff_mag   = cross_diff[30] ? 31'(-cross_diff) : 31'(cross_diff);
   assign round_mag  = 17'((diff_mag + 31'd8192) >> FW);
   assign sat_mag    = (round_mag > 17'(sgai_pkg::ONE_Q14)) ? 16'(sgai_pkg::ONE_Q14)
                                                           : round_mag[15:0];

   // root step: two radicand bits per cycle
   assign rt_sh    = {sq_rem_ff, sq_val_ff[SQV_W-1 -: 2]};
   assign rt_trial = (RT_W+4)'({sq_root_ff, 2'b01});
   assign rt_sub   = rt_sh - rt_trial;
   assign rt_fits  = rt_sh >= rt_trial;

   // step completion
   always_comb begin
      loop_state = 1'b0;
      case (state_ff)
         sgai_pkg::ST_IDLE:  op_done = acc_go;
         sgai_pkg::ST_ACCUM: op_done = 1'b1;
         sgai_pkg::ST_TEST:  op_done = 1'b1;
         sgai_pkg::ST_SQRT:  op_done = busy_ff && (sq_cnt_ff == '0);
         sgai_pkg::ST_NDIV: begin
            loop_state = 1'b1;
            op_done    = (!busy_ff && (root_ff == '0)) || (busy_ff && div_done);
         end
         sgai_pkg::ST_OUT:   op_done = !rsp_valid_ff || !rsp_stall;
         sgai_pkg::ST_SQ_NEW, sgai_pkg::ST_SQ_OLD, sgai_pkg::ST_VAR_SS,
         sgai_pkg::ST_VAR_NQ, sgai_pkg::ST_XR, sgai_pkg::ST_XSQ,
         sgai_pkg::ST_CROSS: begin
            loop_state = 1'b1;
            op_done    = busy_ff && mul_done;
         end
         default:            op_done = busy_ff && mul_done;
      endcase
      last_step = op_done && (!loop_state ||
                  (last_ax && ((state_ff != sgai_pkg::ST_CROSS) || sub_ff)));
   end

   always_comb begin
      state_in = state_ff;
      if (last_step) begin
         case (state_ff)
            sgai_pkg::ST_IDLE:   state_in = sgai_pkg::ST_SQ_NEW;
            sgai_pkg::ST_SQ_NEW: state_in = full ? sgai_pkg::ST_SQ_OLD : sgai_pkg::ST_ACCUM;
            sgai_pkg::ST_SQ_OLD: state_in = sgai_pkg::ST_ACCUM;
            sgai_pkg::ST_ACCUM:  state_in = full ? sgai_pkg::ST_VAR_SS : sgai_pkg::ST_OUT;
            sgai_pkg::ST_VAR_SS: state_in = sgai_pkg::ST_VAR_NQ;
            sgai_pkg::ST_VAR_NQ: state_in = sgai_pkg::ST_LIM0;
            sgai_pkg::ST_LIM0:   state_in = sgai_pkg::ST_LIM1;
            sgai_pkg::ST_LIM1:   state_in = sgai_pkg::ST_LIM2;
            sgai_pkg::ST_LIM2:   state_in = sgai_pkg::ST_TEST;
            sgai_pkg::ST_TEST:   state_in = (spread_ff > lim_ff) ? sgai_pkg::ST_OUT
                                                                 : sgai_pkg::ST_SQRT;
            sgai_pkg::ST_SQRT:   state_in = sgai_pkg::ST_NDIV;
            sgai_pkg::ST_NDIV:   state_in = phase_ff ? sgai_pkg::ST_CROSS : sgai_pkg::ST_XR;
            sgai_pkg::ST_XR:     state_in = sgai_pkg::ST_XSQ;
            sgai_pkg::ST_XSQ:    state_in = sgai_pkg::ST_SQRT;
            sgai_pkg::ST_CROSS:  state_in = sgai_pkg::ST_OUT;
            sgai_pkg::ST_OUT:    state_in = sgai_pkg::ST_IDLE;
            default:             state_in = sgai_pkg::ST_IDLE;
         endcase
      end
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgai_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         ax_ff        <= 2'd0;
         sub_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         max_std_ff   <= 16'd256;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            sqs_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            max_std_ff <= csr_max_std;
         end

         // hold a unit busy from launch until its step completes
         if (op_done) begin
            busy_ff <= 1'b0;
         end else if (!busy_ff && (mul_state || div_start ||
                                   (state_ff == sgai_pkg::ST_SQRT))) begin
            busy_ff <= 1'b1;
         end

         // advance axis and cross sub-step
         if (op_done && loop_state) begin
            if ((state_ff == sgai_pkg::ST_CROSS) && !sub_ff) begin
               sub_ff <= 1'b1;
            end else begin
               sub_ff <= 1'b0;
               ax_ff  <= last_ax ? 2'd0 : ax_ff + 2'd1;
            end
         end

         if ((state_ff == sgai_pkg::ST_TEST) ||
             (state_ff == sgai_pkg::ST_ACCUM)) begin
            phase_ff <= 1'b0;
         end else if ((state_ff == sgai_pkg::ST_XSQ) && last_step) begin
            phase_ff <= 1'b1;
         end

         // slide the window: add the new sample, drop the oldest once full
         if (state_ff == sgai_pkg::ST_ACCUM) begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(smp_ff[i])
                            - (full ? SUM_W'(old_s[i]) : SUM_W'(0));
               sqs_ff[i] <= sqs_ff[i] + SQS_W'(sq_new_ff[i])
                            - (full ? SQS_W'(sq_old_ff[i]) : SQS_W'(0));
            end
            if (full) begin
               wp_ff <= (wp_ff == LOG_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         if ((state_ff == sgai_pkg::ST_OUT) && op_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sample ring: write the new beat in the accumulate step, read the oldest at accept
   always_ff @(posedge clock) begin
      if (state_ff == sgai_pkg::ST_ACCUM) begin
         ring[full ? wp_ff : fill_ff[LOG_W-1:0]] <= {smp_ff[2], smp_ff[1], smp_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (acc_go) begin
         ring_rd_ff <= ring[wp_ff];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (acc_go) begin
         smp_ff[0] <= req_accel_x;
         smp_ff[1] <= req_accel_y;
         smp_ff[2] <= req_accel_z;
      end

      case (state_ff)
         sgai_pkg::ST_SQ_NEW: begin
            if (op_done) sq_new_ff[ax_ff] <= mul_prod[30:0];
         end
         sgai_pkg::ST_SQ_OLD: begin
            if (op_done) sq_old_ff[ax_ff] <= mul_prod[30:0];
         end
         sgai_pkg::ST_ACCUM: begin
            spread_ff <= '0;
            msq_ff    <= '0;
            stat_ff   <= sgai_pkg::STAT_FILL;
         end
         sgai_pkg::ST_VAR_SS: begin
            if (op_done) begin
               spread_ff <= spread_ff - mul_prod[SPR_W-1:0];
               msq_ff    <= msq_ff + mul_prod[SQV_W-1:0];
            end
         end
         sgai_pkg::ST_VAR_NQ: begin
            if (op_done) spread_ff <= spread_ff + mul_prod[SPR_W-1:0];
         end
         sgai_pkg::ST_LIM0, sgai_pkg::ST_LIM1, sgai_pkg::ST_LIM2: begin
            if (op_done) lim_ff <= mul_prod[SPR_W-1:0];
         end
         sgai_pkg::ST_TEST: begin
            stat_ff <= sgai_pkg::STAT_MOVE;
         end
         sgai_pkg::ST_SQRT: begin
            if (!busy_ff) begin
               sq_val_ff  <= msq_ff;
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
               sq_cnt_ff  <= RC_W'(RT_W);
            end else if (sq_cnt_ff != '0) begin
               sq_val_ff  <= sq_val_ff << 2;
               sq_rem_ff  <= rt_fits ? rt_sub[RT_W+1:0] : rt_sh[RT_W+1:0];
               sq_root_ff <= {sq_root_ff[RT_W-2:0], rt_fits};
               sq_cnt_ff  <= sq_cnt_ff - 1'b1;
            end else begin
               root_ff <= sq_root_ff;
            end
         end
         sgai_pkg::ST_NDIV: begin
            if (op_done) begin
               if (phase_ff) begin
                  x_ff[ax_ff] <= (root_ff == '0) ? '0 :
                                 div_neg ? 16'(-signed'(div_quo)) : signed'(div_quo);
               end else begin
                  z_ff[ax_ff] <= (root_ff == '0) ? '0 :
                                 div_neg ? 16'(-signed'(div_quo)) : signed'(div_quo);
               end
               if (last_step) msq_ff <= '0;
            end
         end
         sgai_pkg::ST_XR: begin
            if (op_done) begin
               if (ax_ff == 2'd0) begin
                  xr_ff[0] <= sgai_pkg::ONE_Q28 - signed'(xr_prod);
               end else begin
                  xr_ff[ax_ff] <= XR_W'(-prod_s);
               end
            end
         end
         sgai_pkg::ST_XSQ: begin
            if (op_done) msq_ff <= msq_ff + mul_prod[SQV_W-1:0];
         end
         sgai_pkg::ST_CROSS: begin
            if (op_done) begin
               if (!sub_ff) begin
                  cross_ff <= prod_s;
               end else begin
                  y_ff[ax_ff] <= cross_diff[30] ? 16'(-signed'(sat_mag)) : signed'(sat_mag);
               end
               if (last_step) stat_ff <= sgai_pkg::STAT_VALID;
            end
         end
         sgai_pkg::ST_OUT: begin
            // park the result; rotation reads zero unless the attitude is valid
            if (op_done) begin
               rsp_status_ff <= stat_ff;
               for (int i = 0; i < 3; i++) begin
                  rsp_rot_ff[i]     <= (stat_ff == sgai_pkg::STAT_VALID) ? x_ff[i] : '0;
                  rsp_rot_ff[3 + i] <= (stat_ff == sgai_pkg::STAT_VALID) ? y_ff[i] : '0;
                  rsp_rot_ff[6 + i] <= (stat_ff == sgai_pkg::STAT_VALID) ? z_ff[i] : '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_rot_r0c0 = rsp_rot_ff[0];
   assign rsp_rot_r0c1 = rsp_rot_ff[1];
   assign rsp_rot_r0c2 = rsp_rot_ff[2];
   assign rsp_rot_r1c0 = rsp_rot_ff[3];
   assign rsp_rot_r1c1 = rsp_rot_ff[4];
   assign rsp_rot_r1c2 = rsp_rot_ff[5];
   assign rsp_rot_r2c0 = rsp_rot_ff[6];
   assign rsp_rot_r2c1 = rsp_rot_ff[7];
   assign rsp_rot_r2c2 = rsp_rot_ff[8];

endmodule
